>>> src/sqws_pkg.sv
// ----------------------------------------------------------------------------
// sqws_pkg
// Shared types and constants of the quarter-wave SPWM sequencer.
// ----------------------------------------------------------------------------
package sqws_pkg;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_RETUNE = 2'd2;

    localparam logic RES_TICK = 1'b0;
    localparam logic RES_TUNE = 1'b1;

    localparam logic CFG_KNOB_LOW  = 1'b0;
    localparam logic CFG_KNOB_HIGH = 1'b1;

    localparam int          KNOB_W       = 10;
    localparam int          CMP_W        = 11;
    localparam logic [10:0] PEAK_COMPARE = 11'd1250;
    localparam logic [9:0]  KNOB_HIGH_RST = 10'd1023;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [9:0]        entry_index;
        logic [CMP_W-1:0]  entry_value;
        logic [KNOB_W-1:0] knob_value;
    } in_word_t;

    typedef struct packed {
        logic             result_kind;
        logic [CMP_W-1:0] first_compare;
        logic [CMP_W-1:0] second_compare;
        logic [9:0]       quarter_count;
        logic             negative_half;
    } out_word_t;

    typedef struct packed {
        logic ram_wr;
        logic ram_rd;
        logic latch_knob;
        logic knob_setup;
        logic step_iter;
        logic scale;
        logic div_iter;
        logic commit;
        logic emit_tick;
        logic emit_tune;
    } cmd_t;

    typedef struct packed {
        logic empty_range;
    } status_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_TICK   = 8'b0000_0010,
        ST_KNOB   = 8'b0000_0100,
        ST_STEP   = 8'b0000_1000,
        ST_SCALE  = 8'b0001_0000,
        ST_DIV    = 8'b0010_0000,
        ST_COMMIT = 8'b0100_0000,
        ST_TUNE   = 8'b1000_0000
    } state_t;

endpackage

>>> src/sqws_req_if.sv
// ----------------------------------------------------------------------------
// sqws_req_if
// Request channel: valid/ready handshake carrying one input word.
// ----------------------------------------------------------------------------
interface sqws_req_if;
    import sqws_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/sqws_rsp_if.sv
// ----------------------------------------------------------------------------
// sqws_rsp_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface sqws_rsp_if;
    import sqws_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/sqws_ram.sv
// ----------------------------------------------------------------------------
// sqws_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sqws_ram #(
    parameter  int WIDTH  = 11,
    parameter  int DEPTH  = 641,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

>>> src/sqws_ctrl.sv
// ----------------------------------------------------------------------------
// sqws_ctrl
// Sequencer controller: handshakes, state machine and loop counter.
// ----------------------------------------------------------------------------
module sqws_ctrl #(
    parameter int STEP_ITERS = 9,
    parameter int DIV_ITERS  = 21
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [1:0]          req_type,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  sqws_pkg::status_t   status,
    output sqws_pkg::cmd_t      cmd
);
    import sqws_pkg::*;

    localparam int CNT_MAX = (STEP_ITERS > DIV_ITERS) ? STEP_ITERS : DIV_ITERS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             idle_valid;

    assign out_free   = !out_valid_reg || rsp_ready;
    assign idle_valid = (state_reg == ST_IDLE) && req_valid;
    assign req_ready  = (state_reg == ST_IDLE);
    assign rsp_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;

        cmd.ram_wr     = idle_valid && (req_type == REQ_WRITE);
        cmd.ram_rd     = idle_valid && (req_type == REQ_TICK);
        cmd.latch_knob = idle_valid && (req_type == REQ_RETUNE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.ram_rd)
                begin
                    state_next = ST_TICK;
                end
                else if (cmd.latch_knob)
                begin
                    state_next = ST_KNOB;
                end
            end
            ST_TICK:
            begin
                if (out_free)
                begin
                    cmd.emit_tick = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_KNOB:
            begin
                cmd.knob_setup = 1'b1;
                if (status.empty_range || (STEP_ITERS == 0))
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    cnt_next   = CNT_W'(STEP_ITERS);
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.step_iter = 1'b1;
                cnt_next      = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                cnt_next   = CNT_W'(DIV_ITERS);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_iter = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_TUNE;
            end
            ST_TUNE:
            begin
                if (out_free)
                begin
                    cmd.emit_tune = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_tick || cmd.emit_tune)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

>>> src/sqws_dp.sv
// ----------------------------------------------------------------------------
// sqws_dp
// Sequencer datapath: sine table, phase state, knob step search,
// position rescale multiplier and restoring divider, result register.
// ----------------------------------------------------------------------------
module sqws_dp #(
    parameter int MAX_STEP            = 10,
    parameter int BASE_PERIOD_SAMPLES = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [sqws_pkg::KNOB_W-1:0] cfg_data,
    input  sqws_pkg::in_word_t         in_word,
    input  sqws_pkg::cmd_t             cmd,
    output sqws_pkg::status_t          status,
    output sqws_pkg::out_word_t        out_word
);
    import sqws_pkg::*;

    localparam int FULL_SAMPLES = BASE_PERIOD_SAMPLES * MAX_STEP;
    localparam int QUARTER_MAX  = FULL_SAMPLES / 4;
    localparam int STORE_DEPTH  = QUARTER_MAX + 1;
    localparam int Q_W          = $clog2(STORE_DEPTH);
    localparam int POS_W        = Q_W + 1;
    localparam int PROD_W       = Q_W + POS_W;
    localparam int SW           = $clog2(MAX_STEP + 1);
    localparam int ACC_W        = KNOB_W + SW;

    // quarter count for each frequency step
    logic [Q_W-1:0] qtab [0:MAX_STEP];
    assign qtab[0] = '0;
    for (genvar k = 1; k <= MAX_STEP; k++)
    begin : g_qtab
        localparam int QVAL = (FULL_SAMPLES / k) / 4;
        assign qtab[k] = Q_W'(QVAL);
    end

    logic [KNOB_W-1:0] knob_low_reg, knob_low_next;
    logic [KNOB_W-1:0] knob_high_reg, knob_high_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic              polarity_reg, polarity_next;
    logic [Q_W-1:0]    quarter_reg, quarter_next;

    logic [KNOB_W-1:0] knob_reg, knob_next;
    logic [ACC_W-1:0]  num_reg, num_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [KNOB_W-1:0] den_reg, den_next;
    logic [SW-1:0]     step_reg, step_next;
    logic [Q_W-1:0]    newq_reg, newq_next;
    logic [Q_W-1:0]    rem_reg, rem_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    out_word_t         out_reg, out_next;

    logic [CMP_W-1:0]  ram_rd_data;
    logic [CMP_W-1:0]  wr_value;
    logic              wr_in_range;
    logic [Q_W-1:0]    rd_addr;
    logic [POS_W-1:0]  half;
    logic [POS_W-1:0]  mirror;
    logic [POS_W:0]    pos_inc;
    logic [KNOB_W-1:0] knob_clamped;
    logic [Q_W:0]      trial;
    logic              trial_ge;

    assign status.empty_range = (knob_high_reg <= knob_low_reg);

    assign wr_in_range = (32'(in_word.entry_index) < STORE_DEPTH);
    assign wr_value    = (in_word.entry_value > PEAK_COMPARE) ? PEAK_COMPARE
                                                              : in_word.entry_value;

    assign half    = {quarter_reg, 1'b0};
    assign mirror  = half - position_reg;
    assign rd_addr = (position_reg > {1'b0, quarter_reg}) ? mirror[Q_W-1:0]
                                                           : position_reg[Q_W-1:0];
    assign pos_inc = {1'b0, position_reg} + (POS_W + 1)'(1);

    assign knob_clamped = (knob_reg < knob_low_reg) ? knob_low_reg : knob_reg;
    assign trial        = {rem_reg, quo_reg[PROD_W-1]};
    assign trial_ge     = (trial >= {1'b0, quarter_reg});

    sqws_ram #(
        .WIDTH (CMP_W),
        .DEPTH (STORE_DEPTH)
    ) u_sine_ram (
        .clk     (clk),
        .wr_en   (cmd.ram_wr && wr_in_range),
        .wr_addr (Q_W'(in_word.entry_index)),
        .wr_data (wr_value),
        .rd_en   (cmd.ram_rd),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        knob_low_next  = knob_low_reg;
        knob_high_next = knob_high_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KNOB_LOW:  knob_low_next  = cfg_data;
                CFG_KNOB_HIGH: knob_high_next = cfg_data;
                default:       knob_low_next  = knob_low_reg;
            endcase
        end
    end

    always_comb
    begin
        position_next = position_reg;
        polarity_next = polarity_reg;
        quarter_next  = quarter_reg;
        if (cmd.emit_tick)
        begin
            if (pos_inc >= {1'b0, half})
            begin
                position_next = POS_W'(pos_inc - {1'b0, half});
                polarity_next = !polarity_reg;
            end
            else
            begin
                position_next = pos_inc[POS_W-1:0];
            end
        end
        else if (cmd.commit)
        begin
            if (quo_reg < PROD_W'({newq_reg, 1'b0}))
            begin
                position_next = quo_reg[POS_W-1:0];
            end
            else
            begin
                position_next = '0;
            end
            quarter_next = newq_reg;
        end
    end

    always_comb
    begin
        knob_next = knob_reg;
        num_next  = num_reg;
        acc_next  = acc_reg;
        den_next  = den_reg;
        step_next = step_reg;
        newq_next = newq_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;

        if (cmd.latch_knob)
        begin
            knob_next = in_word.knob_value;
        end
        else if (cmd.knob_setup)
        begin
            num_next = ACC_W'(knob_clamped - knob_low_reg) * ACC_W'(MAX_STEP);
            den_next = knob_high_reg - knob_low_reg;
            acc_next = ACC_W'(knob_high_reg - knob_low_reg);
            if (status.empty_range && (knob_reg > knob_low_reg))
            begin
                step_next = SW'(MAX_STEP);
            end
            else
            begin
                step_next = SW'(1);
            end
        end
        else if (cmd.step_iter)
        begin
            if (acc_reg <= num_reg)
            begin
                step_next = step_reg + SW'(1);
            end
            acc_next = acc_reg + ACC_W'(den_reg);
        end
        else if (cmd.scale)
        begin
            newq_next = qtab[step_reg];
            quo_next  = PROD_W'(qtab[step_reg]) * PROD_W'(position_reg);
            rem_next  = '0;
        end
        else if (cmd.div_iter)
        begin
            if (trial_ge)
            begin
                rem_next = Q_W'(trial - {1'b0, quarter_reg});
            end
            else
            begin
                rem_next = trial[Q_W-1:0];
            end
            quo_next = {quo_reg[PROD_W-2:0], trial_ge};
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.emit_tick)
        begin
            out_next.result_kind    = RES_TICK;
            out_next.first_compare  = polarity_reg ? '0 : ram_rd_data;
            out_next.second_compare = polarity_reg ? ram_rd_data : '0;
            out_next.quarter_count  = 10'(quarter_reg);
            out_next.negative_half  = polarity_reg;
        end
        else if (cmd.emit_tune)
        begin
            out_next.result_kind    = RES_TUNE;
            out_next.first_compare  = '0;
            out_next.second_compare = '0;
            out_next.quarter_count  = 10'(quarter_reg);
            out_next.negative_half  = polarity_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knob_low_reg  <= '0;
            knob_high_reg <= KNOB_HIGH_RST;
            position_reg  <= '0;
            polarity_reg  <= 1'b0;
            quarter_reg   <= Q_W'(BASE_PERIOD_SAMPLES / 4);
        end
        else
        begin
            knob_low_reg  <= knob_low_next;
            knob_high_reg <= knob_high_next;
            position_reg  <= position_next;
            polarity_reg  <= polarity_next;
            quarter_reg   <= quarter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        knob_reg <= knob_next;
        num_reg  <= num_next;
        acc_reg  <= acc_next;
        den_reg  <= den_next;
        step_reg <= step_next;
        newq_reg <= newq_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        out_reg  <= out_next;
    end

    assign out_word = out_reg;
endmodule

>>> src/spwm_quarter_wave_sequencer_unit.sv
// ----------------------------------------------------------------------------
// spwm_quarter_wave_sequencer_unit
// Sinusoidal PWM sequencer over a quarter-wave sine table.
// ----------------------------------------------------------------------------
// Request words arrive on req (valid/ready): tick, table write or retune.
// Result words leave on rsp (valid/ready); ticks and retunes give one word,
// writes and unused codes give none. The user must write the knob range
// registers through cfg_we/cfg_index/cfg_data only while the block is idle;
// the block itself does not enforce this. A write word goes into the table
// RAM as it is accepted. A tick reads the table RAM, then its compare word
// loads the output register once that is free. A retune latches the knob,
// runs the knob step search (skipped for an empty knob range), rescales
// position in the multiplier and restoring divider, one quotient bit per
// cycle, then commits and loads its result once the output register frees.
// Words are worked one at a time; a new word is taken while the previous
// result still waits in the output register. If the receiver stalls, a
// finished result waits and req.ready stays low until the register frees.
// Reset puts position at zero, the positive half, quarter count
// BASE_PERIOD_SAMPLES/4 and the knob range 0..1023; table contents are
// undefined until written.
// ----------------------------------------------------------------------------
module spwm_quarter_wave_sequencer_unit #(
    parameter int MAX_STEP            = 10,
    parameter int BASE_PERIOD_SAMPLES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [sqws_pkg::KNOB_W-1:0] cfg_data,
    sqws_req_if.sink                    req,
    sqws_rsp_if.source                  rsp
);
    import sqws_pkg::*;

    localparam int QUARTER_MAX = (BASE_PERIOD_SAMPLES * MAX_STEP) / 4;
    localparam int Q_W         = $clog2(QUARTER_MAX + 1);
    localparam int PROD_W      = 2 * Q_W + 1;

    cmd_t    cmd;
    status_t status;

    sqws_ctrl #(
        .STEP_ITERS (MAX_STEP - 1),
        .DIV_ITERS  (PROD_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.data.req_type),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sqws_dp #(
        .MAX_STEP            (MAX_STEP),
        .BASE_PERIOD_SAMPLES (BASE_PERIOD_SAMPLES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (req.data),
        .cmd       (cmd),
        .status    (status),
        .out_word  (rsp.data)
    );

`ifndef SYNTH
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.data.req_type == REQ_TICK)) |=> !req.ready)
        else $error("tick accepted but request side still ready");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_tick || cmd.emit_tune) |=> rsp.valid)
        else $error("result loaded but not presented");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_tick || cmd.emit_tune) |-> (!rsp.valid || rsp.ready))
        else $error("result loaded over a word not yet taken");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.data.req_type == REQ_WRITE)) |=> !$rose(rsp.valid))
        else $error("table write produced a result");
`endif
endmodule
